// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/stpr_pkg.sv =====
// ----------------------------------------------------------------------------
// stpr_pkg
// types, constants and the half-step table of the stepper ramp driver
// ----------------------------------------------------------------------------
package stpr_pkg;

    localparam int CfgDataWidth = 16;
    localparam int CfgIndexWidth = 2;

    // register indexes on the configuration port
    typedef enum logic [CfgIndexWidth-1:0] {
        REG_STEP_LIMIT    = 2'd0,
        REG_RAMP_INTERVAL = 2'd1,
        REG_RAMP_MODE     = 2'd2,
        REG_NIBBLE_SELECT = 2'd3
    } cfg_reg_t;

    // ramp modes, code 3 behaves as hold
    typedef enum logic [1:0] {
        RAMP_HOLD  = 2'd0,
        RAMP_ACCEL = 2'd1,
        RAMP_DECEL = 2'd2
    } ramp_mode_t;

    localparam logic [15:0] StepLimitReset    = 16'd40000;
    localparam logic [15:0] RampIntervalReset = 16'd50;
    localparam logic [1:0]  RampModeReset     = 2'd1;

    localparam logic [6:0] StepDelayBase = 7'd70;
    localparam logic [5:0] SpeedUpMax    = 6'd61;
    localparam logic [5:0] SpeedDownMin  = 6'd8;
    localparam logic [5:0] SpeedReset    = 6'd8;
    localparam logic [5:0] SpeedFloor    = 6'd7;
    localparam logic [5:0] SpeedCeil     = 6'd62;

    typedef struct packed {
        logic [15:0] step_limit;
        logic [15:0] ramp_interval;
        logic [1:0]  ramp_mode;
        logic        nibble_select;
    } cfg_t;

    // one item moving from the input stage into the state update
    typedef struct packed {
        logic valid;
        logic tick;
    } adv_t;

    // A-AB-B-BC-C-CD-D-DA
    function automatic logic [3:0] half_step_pattern(input logic [2:0] idx);
        logic [3:0] pat;
        case (idx)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            3'd7:    pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

// ===== src/stpr_if.sv =====
// ----------------------------------------------------------------------------
// stpr_tick_if / stpr_status_if
// valid/ready channels of the stepper ramp driver
// ----------------------------------------------------------------------------
interface stpr_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

interface stpr_status_if;
    logic       valid;
    logic       ready;
    logic [7:0] phase_drive;
    logic [5:0] current_speed;
    logic       finished;

    modport source (output valid, output phase_drive, output current_speed,
                    output finished, input ready);
    modport sink (input valid, input phase_drive, input current_speed,
                  input finished, output ready);
endinterface

// ===== src/stpr_ramp.sv =====
// ----------------------------------------------------------------------------
// stpr_ramp
// time count and speed ramp state
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stpr_ramp
    import stpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  adv_t        adv,
    input  cfg_t        cfg,
    output logic [15:0] time_next,
    output logic [5:0]  speed_next
);

    logic [15:0] time_reg;
    logic [15:0] ramp_stamp_reg;
    logic [15:0] ramp_stamp_next;
    logic [5:0]  speed_reg;
    logic [15:0] since;
    logic        ramp_fire;

    always_comb
    begin
        time_next = time_reg + {15'd0, adv.tick};
        // wrapping distance since the last ramp change
        since = time_next - ramp_stamp_reg;
        ramp_fire = (since >= cfg.ramp_interval);
        ramp_stamp_next = ramp_fire ? time_next : ramp_stamp_reg;
        speed_next = speed_reg;
        if (ramp_fire)
        begin
            case (cfg.ramp_mode)
                RAMP_ACCEL:
                begin
                    if (speed_reg <= SpeedUpMax)
                        speed_next = speed_reg + 6'd1;
                end
                RAMP_DECEL:
                begin
                    if (speed_reg >= SpeedDownMin)
                        speed_next = speed_reg - 6'd1;
                end
                default: speed_next = speed_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            ramp_stamp_reg <= '0;
            speed_reg      <= SpeedReset;
        end
        else if (adv.valid)
        begin
            time_reg       <= time_next;
            ramp_stamp_reg <= ramp_stamp_next;
            speed_reg      <= speed_next;
        end
    end

    `ASSERT_ALWAYS(a_speed_range, clk, rst_n,
        speed_reg >= SpeedFloor && speed_reg <= SpeedCeil)
    `ASSERT_NEXT(a_time_holds, clk, rst_n, !adv.valid, time_reg == $past(time_reg))

endmodule

// ===== src/stpr_step.sv =====
// ----------------------------------------------------------------------------
// stpr_step
// step timing, phase sequence and step count
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stpr_step
    import stpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  adv_t        adv,
    input  cfg_t        cfg,
    input  logic [15:0] time_next,
    input  logic [5:0]  speed_next,
    output logic [7:0]  drive_next,
    output logic        finished_next
);

    logic [15:0] step_stamp_reg;
    logic [15:0] step_stamp_next;
    logic [15:0] steps_done_reg;
    logic [15:0] steps_done_next;
    logic [2:0]  phase_index_reg;
    logic [2:0]  phase_index_next;
    logic [7:0]  drive_hold_reg;
    logic [6:0]  delay;
    logic [15:0] since;
    logic        step_ok;
    logic        step_fire;
    logic [3:0]  pat;

    always_comb
    begin
        // count saturates, no step once it is all ones
        step_ok = (steps_done_reg <= cfg.step_limit) && (steps_done_reg != 16'hFFFF);
        delay = StepDelayBase - {1'b0, speed_next};
        since = time_next - step_stamp_reg;
        step_fire = step_ok && (since >= {9'd0, delay});
        pat = half_step_pattern(phase_index_reg);

        step_stamp_next  = step_stamp_reg;
        steps_done_next  = steps_done_reg;
        phase_index_next = phase_index_reg;
        drive_next       = drive_hold_reg;
        if (step_fire)
        begin
            step_stamp_next  = time_next;
            steps_done_next  = steps_done_reg + 16'd1;
            phase_index_next = phase_index_reg + 3'd1;
            drive_next       = cfg.nibble_select ? {pat, 4'h0} : {4'h0, pat};
        end
        finished_next = (steps_done_next > cfg.step_limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_stamp_reg  <= '0;
            steps_done_reg  <= '0;
            phase_index_reg <= '0;
            drive_hold_reg  <= '0;
        end
        else if (adv.valid)
        begin
            step_stamp_reg  <= step_stamp_next;
            steps_done_reg  <= steps_done_next;
            phase_index_reg <= phase_index_next;
            drive_hold_reg  <= drive_next;
        end
    end

    `ASSERT_ALWAYS(a_one_nibble, clk, rst_n,
        drive_hold_reg[7:4] == 4'h0 || drive_hold_reg[3:0] == 4'h0)
    `ASSERT_IMPLIES(a_count_step, clk, rst_n,
        steps_done_reg != $past(steps_done_reg),
        steps_done_reg == $past(steps_done_reg) + 16'd1
        && phase_index_reg == $past(phase_index_reg) + 3'd1)

endmodule

// ===== src/stepper_half_step_ramp_driver.sv =====
// ----------------------------------------------------------------------------
// stepper_half_step_ramp_driver
// one half-step stepper channel with speed ramp, driven by tick items
// ----------------------------------------------------------------------------
// Takes one item per clock while the output side is ready and returns one status
// item for each: the item is captured in an input register, the ramp and
// step updates of the channel state run in compare-and-add logic, and the
// status lands in a result register. The channel state is updated as each
// item advances, so back-to-back items see each other's updates.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while no item is in flight, which the block
// itself does not enforce. The nibble choice takes effect at the next step.
`include "assert_macros.svh"

module stepper_half_step_ramp_driver
    import stpr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    stpr_tick_if.sink                tick_ch,
    stpr_status_if.source            status_ch,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic        in_tick_reg;
    logic        out_valid_reg;
    logic [7:0]  drive_reg;
    logic [5:0]  speed_out_reg;
    logic        finished_reg;
    logic        advance;
    logic        accept;
    adv_t        adv;
    logic [15:0] time_next;
    logic [5:0]  speed_next;
    logic [7:0]  drive_next;
    logic        finished_next;

    always_comb
    begin
        advance = in_valid_reg && (!out_valid_reg || status_ch.ready);
        accept = tick_ch.valid && tick_ch.ready;
        adv.valid = advance;
        adv.tick = in_tick_reg;
    end

    assign tick_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_limit    <= StepLimitReset;
            cfg_reg.ramp_interval <= RampIntervalReset;
            cfg_reg.ramp_mode     <= RampModeReset;
            cfg_reg.nibble_select <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_STEP_LIMIT:    cfg_reg.step_limit    <= cfg_data;
                REG_RAMP_INTERVAL: cfg_reg.ramp_interval <= cfg_data;
                REG_RAMP_MODE:     cfg_reg.ramp_mode     <= cfg_data[1:0];
                REG_NIBBLE_SELECT: cfg_reg.nibble_select <= cfg_data[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (status_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_tick_reg <= tick_ch.tick;
        if (advance)
        begin
            drive_reg     <= drive_next;
            speed_out_reg <= speed_next;
            finished_reg  <= finished_next;
        end
    end

    stpr_ramp u_ramp (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .cfg        (cfg_reg),
        .time_next  (time_next),
        .speed_next (speed_next)
    );

    stpr_step u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .cfg           (cfg_reg),
        .time_next     (time_next),
        .speed_next    (speed_next),
        .drive_next    (drive_next),
        .finished_next (finished_next)
    );

    assign status_ch.valid         = out_valid_reg;
    assign status_ch.phase_drive   = drive_reg;
    assign status_ch.current_speed = speed_out_reg;
    assign status_ch.finished      = finished_reg;

    // a stalled result keeps the waiting input item in place
    `ASSERT_NEXT(a_stall_holds_input, clk, rst_n,
        in_valid_reg && out_valid_reg && !status_ch.ready, in_valid_reg)
    `ASSERT_NEXT(a_advance_fills_output, clk, rst_n, advance, out_valid_reg)

endmodule
